/* rtl/core/vgbcf_pkg.sv */
// shared types, constants and helpers of the voxel grid box clear and fill block
`default_nettype none

package vgbcf_pkg;

  localparam int MAX_DIM_DEF = 64;

  localparam int GRID_DIM_W = 7;
  localparam int SEED_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 16;
  localparam int THR_W      = 17;
  localparam int CIDX_W     = 18;
  localparam int STATE_W    = 2;
  localparam int COUNT_W    = 19;
  localparam int DRAW_W     = 16;

  localparam logic [GRID_DIM_W-1:0] GRID_DIM_RST = 7'd40;
  localparam logic [SEED_W-1:0]     SEED_RST     = 32'd1;
  localparam logic [SEED_W-1:0]     LFSR_MASK    = 32'hD000_0001;

  // item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // cell states
  localparam logic [STATE_W-1:0] VOX_FREE = 2'd0;
  localparam logic [STATE_W-1:0] VOX_OFF  = 2'd1;
  localparam logic [STATE_W-1:0] VOX_ON   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIM    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 1'b1;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_SETUP,
    S_TOTAL,
    S_ZBASE,
    S_YOFF,
    S_SUM_Y,
    S_SUM_X,
    S_CLEAR,
    S_FILL,
    S_QREAD,
    S_QDATA,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] x_low;
    logic signed [COORD_W-1:0] y_low;
    logic signed [COORD_W-1:0] z_low;
    logic signed [COORD_W-1:0] x_high;
    logic signed [COORD_W-1:0] y_high;
    logic signed [COORD_W-1:0] z_high;
    logic [THR_W-1:0]          fill_threshold;
    logic [CIDX_W-1:0]         cell_index;
  } in_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] cell_state;
    logic [COUNT_W-1:0] cells_changed;
  } out_item_t;

  // one right shift of the galois lfsr
  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
    lfsr_step = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/vgbcf_if.sv */
// valid/ready channel interfaces for items and results
`default_nettype none

interface vgbcf_in_if;
  logic                valid;
  logic                ready;
  vgbcf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vgbcf_out_if;
  logic                 valid;
  logic                 ready;
  vgbcf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/voxel_grid_box_clear_fill.sv */
// top level: voxel occupancy grid with box clear, random fill and cell query
// a query sets up the grid size, reads the cell and answers; a fill sets up the size and walks every
// cell; a clear sets up the box address, then walks its cells; an empty box or an unused kind goes
// straight to the result; one item at a time, set by the cell walk at one cell a cycle over the cell
// memory and the shared multiplier for address setup; after reset a sweep writes every cell free;
// no item is taken meanwhile, config writes are; registers reset to grid_dim 40 and lfsr 1
`default_nettype none

module voxel_grid_box_clear_fill #(
  parameter int MAX_DIM = vgbcf_pkg::MAX_DIM_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [vgbcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [vgbcf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  vgbcf_in_if.sink                             item_i,
  vgbcf_out_if.source                          result_o
);
  import vgbcf_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W = $clog2(CELLS);
  localparam int TOT_W = IDX_W + 1;
  localparam int MUL_W = IDX_W + DIM_W;
  localparam int GW    = (DIM_W > GRID_DIM_W) ? DIM_W : GRID_DIM_W;
  localparam int QW    = (TOT_W > CIDX_W) ? TOT_W : CIDX_W;
  localparam int CW    = COORD_W + 1;

  localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(CELLS - 1);

  // sequencer
  state_e state_q, state_d;

  // configuration
  logic [GRID_DIM_W-1:0] grid_dim_q;
  logic [SEED_W-1:0]     lfsr_q;

  // item and working registers
  in_item_t           item_q;
  logic [IDX_W-1:0]   sweep_q;
  logic [IDX_W-1:0]   d2_q;       // dim squared
  logic [TOT_W-1:0]   total_q;    // dim cubed
  logic [DIM_W-1:0]   x0_q, x1_q, y0_q, y1_q, z0_q, z1_q;
  logic [DIM_W-1:0]   x_q, y_q, z_q;
  logic [IDX_W-1:0]   planex_q;   // address of (x0, y0, z)
  logic [IDX_W-1:0]   rowx_q;     // address of (x0, y, z)
  logic [IDX_W-1:0]   yoff_q;
  logic [IDX_W-1:0]   addr_q;
  logic [TOT_W-1:0]   fidx_q;     // fill read pointer
  logic               pend_v_q;   // a fill read is in flight
  logic [IDX_W-1:0]   pend_addr_q;
  logic               qin_q;      // query index inside the grid
  logic [COUNT_W-1:0] count_q;
  logic [STATE_W-1:0] res_state_q;

  // output register
  logic      out_valid_q;
  out_item_t out_data_q;

  // cell memory
  logic [STATE_W-1:0] mem [CELLS];
  logic [STATE_W-1:0] rdata_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [STATE_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;

  // shared multiplier
  logic [IDX_W-1:0] mul_a;
  logic [DIM_W-1:0] mul_b;
  logic [MUL_W-1:0] mul_p;

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // effective dimension: zero acts as one, large values saturate
  logic [GW-1:0]    gd_ext;
  logic [DIM_W-1:0] dim;
  logic [DIM_W-1:0] dm1;

  always_comb begin
    gd_ext = GW'(grid_dim_q);
    if (gd_ext == '0) begin
      dim = DIM_W'(1);
    end else if (gd_ext > GW'(MAX_DIM)) begin
      dim = DIM_W'(MAX_DIM);
    end else begin
      dim = gd_ext[DIM_W-1:0];
    end
    dm1 = dim - DIM_W'(1);
  end

  // box clamp on all three axes at once
  logic signed [CW-1:0] dm1_s;
  logic signed [CW-1:0] xl, xh, yl, yh, zl, zh;
  logic signed [CW-1:0] xl_c, xh_c, yl_c, yh_c, zl_c, zh_c;
  logic                 box_empty;

  always_comb begin
    dm1_s = $signed(CW'(dm1));
    xl = CW'(item_q.x_low);
    yl = CW'(item_q.y_low);
    zl = CW'(item_q.z_low);
    xh = CW'(item_q.x_high);
    yh = CW'(item_q.y_high);
    zh = CW'(item_q.z_high);
    xl_c = (xl < 0) ? '0 : xl;
    yl_c = (yl < 0) ? '0 : yl;
    zl_c = (zl < 0) ? '0 : zl;
    xh_c = (xh > dm1_s) ? dm1_s : xh;
    yh_c = (yh > dm1_s) ? dm1_s : yh;
    zh_c = (zh > dm1_s) ? dm1_s : zh;
    box_empty = (xl_c > xh_c) || (yl_c > yh_c) || (zl_c > zh_c);
  end

  // random draw for the cell whose read data is back
  logic [SEED_W-1:0] lfsr_next;
  logic [DRAW_W-1:0] draw;
  logic              fill_free;
  logic              fill_hit;

  always_comb begin
    lfsr_next = lfsr_step(lfsr_q);
    draw      = lfsr_next[SEED_W-1 -: DRAW_W];
    fill_free = pend_v_q && (rdata_q == VOX_FREE);
    fill_hit  = fill_free && (THR_W'(draw) < item_q.fill_threshold);
  end

  logic               clr_last;
  logic               fill_end;
  logic [COUNT_W-1:0] count_inc;
  logic               out_load;

  assign clr_last  = (x_q == x1_q) && (y_q == y1_q) && (z_q == z1_q);
  assign fill_end  = (fidx_q == total_q) && !pend_v_q;
  assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || result_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_SWEEP: if (sweep_q == SWEEP_LAST) state_d = S_IDLE;
      S_IDLE:  if (item_i.valid) state_d = S_SETUP;
      S_SETUP: begin
        case (item_q.kind) inside
          KIND_CLEAR:             state_d = box_empty ? S_DONE : S_ZBASE;
          KIND_FILL, KIND_QUERY:  state_d = S_TOTAL;
          default:                state_d = S_DONE;
        endcase
      end
      S_TOTAL: state_d = (item_q.kind == KIND_FILL) ? S_FILL : S_QREAD;
      S_ZBASE: state_d = S_YOFF;
      S_YOFF:  state_d = S_SUM_Y;
      S_SUM_Y: state_d = S_SUM_X;
      S_SUM_X: state_d = S_CLEAR;
      S_CLEAR: if (clr_last) state_d = S_DONE;
      S_FILL:  if (fill_end) state_d = S_DONE;
      S_QREAD: state_d = S_QDATA;
      S_QDATA: state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, memory port, multiplier operands
  always_comb begin
    item_i.ready = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = VOX_OFF;
    mem_raddr    = fidx_q[IDX_W-1:0];
    mul_a        = '0;
    mul_b        = '0;
    unique case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = VOX_FREE;
      end
      S_IDLE:  item_i.ready = 1'b1;
      S_SETUP: begin
        mul_a = IDX_W'(dim);
        mul_b = dim;
      end
      S_TOTAL: begin
        mul_a = d2_q;
        mul_b = dim;
      end
      S_ZBASE: begin
        mul_a = d2_q;
        mul_b = z0_q;
      end
      S_YOFF: begin
        mul_a = IDX_W'(dim);
        mul_b = y0_q;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = VOX_OFF;
      end
      S_FILL: begin
        mem_we    = fill_hit;
        mem_waddr = pend_addr_q;
        mem_wdata = VOX_ON;
        mem_raddr = fidx_q[IDX_W-1:0];
      end
      S_QREAD: mem_raddr = IDX_W'(item_q.cell_index);
      default: ;
    endcase
  end

  // cell memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      grid_dim_q  <= GRID_DIM_RST;
      lfsr_q      <= SEED_RST;
    end else begin
      state_q <= state_d;
      if (state_q == S_SWEEP) begin
        sweep_q <= sweep_q + IDX_W'(1);
      end
      // fill pipeline: read pointer one ahead of the cell being decided
      if (state_q == S_FILL && fidx_q != total_q) begin
        pend_v_q <= 1'b1;
      end else begin
        pend_v_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // config write wins over a draw; the user is to write only while idle, the block does not enforce it
      if (cfg_we_i && cfg_idx_i == CFG_GRID_DIM) begin
        grid_dim_q <= cfg_data_i[GRID_DIM_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_RANDOM_SEED) begin
        lfsr_q <= (cfg_data_i[SEED_W-1:0] == '0) ? SEED_RST : cfg_data_i[SEED_W-1:0];
      end else if (state_q == S_FILL && fill_free) begin
        lfsr_q <= lfsr_next;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          item_q      <= item_i.data;
          count_q     <= '0;
          res_state_q <= VOX_FREE;
        end
      end
      S_SETUP: begin
        d2_q <= mul_p[IDX_W-1:0];
        x0_q <= xl_c[DIM_W-1:0];
        x1_q <= xh_c[DIM_W-1:0];
        y0_q <= yl_c[DIM_W-1:0];
        y1_q <= yh_c[DIM_W-1:0];
        z0_q <= zl_c[DIM_W-1:0];
        z1_q <= zh_c[DIM_W-1:0];
      end
      S_TOTAL: begin
        total_q <= mul_p[TOT_W-1:0];
        fidx_q  <= '0;
      end
      S_ZBASE: planex_q <= mul_p[IDX_W-1:0];
      S_YOFF:  yoff_q   <= mul_p[IDX_W-1:0];
      S_SUM_Y: planex_q <= planex_q + yoff_q;
      S_SUM_X: begin
        planex_q <= planex_q + IDX_W'(x0_q);
        rowx_q   <= planex_q + IDX_W'(x0_q);
        addr_q   <= planex_q + IDX_W'(x0_q);
        x_q      <= x0_q;
        y_q      <= y0_q;
        z_q      <= z0_q;
      end
      S_CLEAR: begin
        // every covered cell counts, whatever it held
        count_q <= count_inc;
        if (x_q != x1_q) begin
          x_q    <= x_q + DIM_W'(1);
          addr_q <= addr_q + IDX_W'(1);
        end else begin
          x_q <= x0_q;
          if (y_q != y1_q) begin
            y_q    <= y_q + DIM_W'(1);
            rowx_q <= rowx_q + IDX_W'(dim);
            addr_q <= rowx_q + IDX_W'(dim);
          end else begin
            y_q      <= y0_q;
            z_q      <= z_q + DIM_W'(1);
            planex_q <= planex_q + d2_q;
            rowx_q   <= planex_q + d2_q;
            addr_q   <= planex_q + d2_q;
          end
        end
      end
      S_FILL: begin
        if (fidx_q != total_q) begin
          fidx_q      <= fidx_q + TOT_W'(1);
          pend_addr_q <= fidx_q[IDX_W-1:0];
        end
        if (fill_hit) begin
          count_q <= count_inc;
        end
      end
      S_QREAD: qin_q <= QW'(item_q.cell_index) < QW'(total_q);
      S_QDATA: res_state_q <= qin_q ? rdata_q : VOX_FREE;
      S_DONE: begin
        if (out_load) begin
          out_data_q.cell_state    <= res_state_q;
          out_data_q.cells_changed <= count_q;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

endmodule

`default_nettype wire

/* bench/voxel_grid_box_clear_fill_tb.sv */
// self-checking bench for the voxel grid block: box clears, random fills and cell queries
`timescale 1ns / 100ps

module voxel_grid_box_clear_fill_tb;
  import vgbcf_pkg::*;

  // grid geometry as the bench sees it, same default as the block
  localparam int GRID_MAX = MAX_DIM_DEF;
  localparam int CELL_SLOTS = GRID_MAX * GRID_MAX * GRID_MAX;

  // galois feedback taps of the fill draw generator
  localparam logic [SEED_W-1:0] TAP_MASK = 32'hD000_0001;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  // kind code the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // fills walk up to 4096 cells each in the random part, plus one full 64^3 walk,
  // the 64^3 sweep after reset and long receiver stalls: this sits far above all that
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_SETTING = 65;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  vgbcf_in_if  item_if ();
  vgbcf_out_if res_if ();

  voxel_grid_box_clear_fill u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .item_i    (item_if),
    .result_o  (res_if)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // mirror of the grid: cell states, dimension register and draw generator
  // ---------------------------------------------------------------------------
  logic [STATE_W-1:0]    cell_mirror [CELL_SLOTS];
  logic [GRID_DIM_W-1:0] dim_reg;
  logic [SEED_W-1:0]     lfsr_reg;

  in_item_t  pending_items [$];   // beats waiting for the driver
  out_item_t results_due [$];     // one per accepted item, oldest first

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  logic hold_kick = 1'b0;
  logic item_took = 1'b0;

  // dimension in use: zero acts as one, anything past the grid saturates
  function automatic int active_dim();
    if (dim_reg == '0) return 1;
    if (int'(dim_reg) > GRID_MAX) return GRID_MAX;
    return int'(dim_reg);
  endfunction

  // applies one item to the mirror and returns the result the block owes for it
  function automatic out_item_t grid_apply(input in_item_t it);
    out_item_t r;
    logic [COUNT_W-1:0] n;
    int d, cells, x, y, z, i;
    int lo [3];
    int hi [3];
    r = '0;
    n = '0;
    d = active_dim();
    cells = d * d * d;
    case (it.kind)
      KIND_CLEAR: begin
        lo[0] = $signed(it.x_low);
        lo[1] = $signed(it.y_low);
        lo[2] = $signed(it.z_low);
        hi[0] = $signed(it.x_high);
        hi[1] = $signed(it.y_high);
        hi[2] = $signed(it.z_high);
        // clamp every axis to the grid, inclusive bounds
        for (i = 0; i < 3; i++) begin
          if (lo[i] < 0) lo[i] = 0;
          if (hi[i] > d - 1) hi[i] = d - 1;
        end
        // an inverted axis after clamping leaves the grid untouched
        if (lo[0] <= hi[0] && lo[1] <= hi[1] && lo[2] <= hi[2]) begin
          for (z = lo[2]; z <= hi[2]; z++)
            for (y = lo[1]; y <= hi[1]; y++)
              for (x = lo[0]; x <= hi[0]; x++) begin
                cell_mirror[z * d * d + y * d + x] = VOX_OFF;
                if (n != COUNT_TOP) n = n + 1'b1;
              end
        end
      end
      KIND_FILL: begin
        // only free cells consume a draw
        for (i = 0; i < cells; i++) begin
          if (cell_mirror[i] == VOX_FREE) begin
            lfsr_reg = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ TAP_MASK) : (lfsr_reg >> 1);
            if (int'(lfsr_reg[31:16]) < int'(it.fill_threshold)) begin
              cell_mirror[i] = VOX_ON;
              if (n != COUNT_TOP) n = n + 1'b1;
            end
          end
        end
      end
      KIND_QUERY: begin
        // out-of-range index answers free
        if (int'(it.cell_index) < cells) r.cell_state = cell_mirror[it.cell_index];
      end
      default: ;
    endcase
    r.cells_changed = n;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------
  function automatic in_item_t clear_item(input int xl, input int yl, input int zl,
                                          input int xh, input int yh, input int zh);
    in_item_t it;
    it = '0;
    it.kind   = KIND_CLEAR;
    it.x_low  = 16'(xl);
    it.y_low  = 16'(yl);
    it.z_low  = 16'(zl);
    it.x_high = 16'(xh);
    it.y_high = 16'(yh);
    it.z_high = 16'(zh);
    return it;
  endfunction

  function automatic in_item_t fill_item(input int thr);
    in_item_t it;
    it = '0;
    it.kind = KIND_FILL;
    it.fill_threshold = THR_W'(thr);
    return it;
  endfunction

  function automatic in_item_t query_item(input int idx);
    in_item_t it;
    it = '0;
    it.kind = KIND_QUERY;
    it.cell_index = CIDX_W'(idx);
    return it;
  endfunction

  // a short span near the grid, now and then poking below zero or past the top
  function automatic void small_span(input int d, output logic [COORD_W-1:0] lo,
                                     output logic [COORD_W-1:0] hi);
    int a, b;
    a = $urandom_range(d - 1);
    b = a + $urandom_range(3);
    if ($urandom_range(7) == 0) a = a - $urandom_range(4, 1);
    lo = COORD_W'(a);
    hi = COORD_W'(b);
  endfunction

  // random item for a grid of d cells per axis; fields a kind ignores stay random
  function automatic in_item_t make_item(input int d);
    in_item_t it;
    logic [159:0] noise;
    int roll, pick, cells;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    cells = d * d * d;
    roll = $urandom_range(99);
    if (roll < 35) begin
      it.kind = KIND_CLEAR;
      pick = $urandom_range(9);
      if (pick < 6 || (pick < 8 && d > 16)) begin
        small_span(d, it.x_low, it.x_high);
        small_span(d, it.y_low, it.y_high);
        small_span(d, it.z_low, it.z_high);
      end else if (pick >= 8) begin
        // inverted on one axis: nothing may be written
        small_span(d, it.x_low, it.x_high);
        small_span(d, it.y_low, it.y_high);
        small_span(d, it.z_low, it.z_high);
        case ($urandom_range(2))
          0:       it.x_high = it.x_low - 1'b1;
          1:       it.y_high = it.y_low - 1'b1;
          default: it.z_high = it.z_low - 1'b1;
        endcase
      end
      // otherwise full 16-bit corners, mostly empty, sometimes the whole grid
    end else if (roll < 60 && d <= 16) begin
      it.kind = KIND_FILL;
      pick = $urandom_range(19);
      // low odds most of the time so that free cells last
      if (pick < 13)      it.fill_threshold = THR_W'($urandom_range(4095));
      else if (pick < 16) it.fill_threshold = THR_W'($urandom_range(65535));
      else if (pick < 19) it.fill_threshold = THR_W'($urandom_range(131071, 65536));
      else                it.fill_threshold = '0;
    end else if (roll < 96) begin
      it.kind = KIND_QUERY;
      pick = $urandom_range(9);
      if (pick < 8)       it.cell_index = CIDX_W'($urandom_range(cells - 1));
      else if (pick == 8) it.cell_index = CIDX_W'(cells + $urandom_range(3));
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  // appends a beat to the driver queue
  function automatic void queue_item(input in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // driver: offers beats at the falling edge, holds a beat until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!item_if.valid || item_took) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          item_if.valid <= 1'b1;
          item_if.data  <= pending_items.pop_front();
        end else begin
          item_if.valid <= 1'b0;
        end
      end
      // result side backs off at random, or for the whole hold-off stretch
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: register writes and item beats feed the mirror, result beats are checked
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      item_took <= 1'b0;
    end else begin
      item_took <= item_if.valid && item_if.ready;
      if (cfg_we) begin
        if (cfg_idx == CFG_GRID_DIM) begin
          dim_reg = cfg_data[GRID_DIM_W-1:0];
        end else begin
          // a zero seed would lock the generator, the block loads one instead
          lfsr_reg = (cfg_data == '0) ? SEED_W'(1) : cfg_data;
        end
      end
      if (item_if.valid && item_if.ready)
        results_due.insert(results_due.size(), grid_apply(item_if.data));
      if (res_if.valid && res_if.ready) begin
        if (results_due.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = results_due.pop_front();
          if (res_if.data.cell_state !== want.cell_state)
            flag_mismatch($sformatf("cell_state got %0d want %0d",
                                    res_if.data.cell_state, want.cell_state));
          if (res_if.data.cells_changed !== want.cells_changed)
            flag_mismatch($sformatf("cells_changed got %0d want %0d",
                                    res_if.data.cells_changed, want.cells_changed));
        end
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk_i) begin
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("voxel_grid_box_clear_fill_tb: FAIL");
      $finish;
    end
  end

  // register write, only ever issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // every item offered, taken and answered; one result per item so nothing lingers
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || item_if.valid || results_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t stray;
    int seg, sub, pick, dimv, d;

    item_if.valid = 1'b0;
    item_if.data  = '0;
    res_if.ready  = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    foreach (cell_mirror[i]) cell_mirror[i] = VOX_FREE;
    dim_reg  = GRID_DIM_RST;
    lfsr_reg = SEED_RST;

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender idles a third of the time, receiver three quarters
    tx_idle_pct = 33;
    rx_idle_pct = 75;

    // reset settings: 40 cells per axis, seed one; first beat waits out the sweep
    queue_item(query_item(0));
    queue_item(query_item(63999));          // last cell in range
    queue_item(query_item(64000));          // first cell past the grid
    queue_item(query_item(262143));         // top of the index field
    queue_item(clear_item(-32768, -5, 38, 1, 0, 32767));  // clamps to 4 cells
    queue_item(clear_item(5, 0, 0, 4, 3, 3));             // inverted x
    queue_item(clear_item(0, 0, 32767, 3, 3, 32767));     // z beyond the grid
    queue_item(query_item(60800));          // corner cell just cleared
    stray = query_item(5);
    stray.kind = KIND_UNUSED;
    queue_item(stray);
    queue_item(fill_item(2000));
    wait_drained();

    // largest grid, all-ones seed
    write_reg(CFG_GRID_DIM, CFG_DATA_W'(64));
    write_reg(CFG_RANDOM_SEED, 32'hFFFF_FFFF);
    queue_item(clear_item(62, 63, -1, 32767, 63, 63));    // 128 cells at the far edge
    queue_item(query_item(262143));
    queue_item(fill_item(0));               // full walk, draws advance, nothing set
    queue_item(query_item(262142));
    wait_drained();

    // zero dimension acts as one, zero seed loads one
    write_reg(CFG_GRID_DIM, '0);
    write_reg(CFG_RANDOM_SEED, '0);
    queue_item(clear_item(-1, -1, -1, 0, 0, 0));
    queue_item(query_item(0));
    queue_item(query_item(1));
    queue_item(fill_item(65536));           // no free cell left to draw for
    wait_drained();

    // dimension field at its top saturates to the grid size
    write_reg(CFG_GRID_DIM, CFG_DATA_W'(127));
    write_reg(CFG_RANDOM_SEED, $urandom);
    queue_item(clear_item(63, 63, 63, 63, 63, 63));       // one cell already off
    queue_item(query_item(262143));
    queue_item(query_item(0));
    wait_drained();

    // threshold of exactly one turns on every free cell
    write_reg(CFG_GRID_DIM, CFG_DATA_W'(2));
    queue_item(fill_item(65536));
    queue_item(query_item(5));
    wait_drained();

    // threshold past one behaves the same, draws still move
    write_reg(CFG_GRID_DIM, CFG_DATA_W'(3));
    queue_item(fill_item(131071));
    queue_item(query_item(20));
    wait_drained();

    // random part: three idle patterns, six grid settings each
    for (seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 75;
        end
        1: begin
          tx_idle_pct = 75;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (sub = 0; sub < 6; sub++) begin
        // small grids keep fills cheap; a few mid, zero and saturating settings
        pick = $urandom_range(19);
        if (pick < 16)       dimv = $urandom_range(12, 1);
        else if (pick < 18)  dimv = $urandom_range(24, 13);
        else if (pick == 18) dimv = 0;
        else                 dimv = $urandom_range(127, 64);
        write_reg(CFG_GRID_DIM, CFG_DATA_W'(dimv));
        if ($urandom_range(1) == 1)
          write_reg(CFG_RANDOM_SEED, ($urandom_range(7) == 0) ? '0 : $urandom);
        d = active_dim();
        repeat (ITEMS_PER_SETTING) queue_item(make_item(d));
        if (seg == 2 && sub == 0) begin
          // receiver goes quiet while the sender keeps offering
          hold_kick <= 1'b1;
          @(negedge clk_i);
          hold_kick <= 1'b0;
        end
        wait_drained();
      end
    end

    // let any stray beat show up before the verdict
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("voxel_grid_box_clear_fill_tb: PASS");
    end else begin
      $display("voxel_grid_box_clear_fill_tb: FAIL");
    end
    $finish;
  end

endmodule

/* voxel_grid_box_clear_fill.f */
rtl/core/vgbcf_pkg.sv
rtl/core/vgbcf_if.sv
rtl/core/voxel_grid_box_clear_fill.sv
bench/voxel_grid_box_clear_fill_tb.sv
